@@ sv/tdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Trial division prime counter package
// Shared widths and constants for the prime counter and its checker.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // Width of the candidate field on the input port.
  localparam int unsigned CAND_W = 17;

  // Width of the running prime total on the output port.
  localparam int unsigned TOTAL_W = 17;

  // The running total saturates at this value.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 17'h1FFFF;

  // Smallest trial divisor, and smallest prime.
  localparam int unsigned FIRST_DIVISOR = 2;

endpackage

@@ sv/trial_division_prime_counter.sv @@
// ----------------------------------------------------------------------------
// Trial division prime counter
// Tests one candidate per item for primality and keeps a running prime count.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Candidates below two go straight to the
// finish state. Otherwise each trial divisor d from 2 upward with d*d <= candidate
// takes one check of d*d against the candidate and a bit-serial restoring
// remainder that shifts one candidate bit per cycle. An item stops early at the
// first divisor that leaves no remainder. The result sits in an output register,
// so a new item is accepted while the previous result still waits to be taken.
// The running total saturates at its maximum and is cleared by an item's restart
// flag before that item is counted.
module trial_division_prime_counter
  import tdpc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CAND_W-1:0]  candidate_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_prime_flag_o,
  output logic [TOTAL_W-1:0] prime_total_o
);

  // Only the low bits of the candidate take part, up to the port width.
  localparam int unsigned VW = (VALUE_BITS < CAND_W) ? VALUE_BITS : CAND_W;
  localparam int unsigned CW = (VW > 1) ? $clog2(VW) : 1;
  localparam int unsigned SW = VW + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [VW-1:0]      value_q;
  logic               restart_q;
  logic [VW-1:0]      div_q;
  logic [SW-1:0]      sq_q;
  logic [VW-1:0]      sh_q;
  logic [VW-1:0]      rem_q;
  logic [CW-1:0]      cnt_q;
  logic               prime_q;
  logic               out_valid_q;
  logic               flag_q;
  logic [TOTAL_W-1:0] total_q;

  logic [VW-1:0]      cand_bits;
  logic [VW:0]        trial_rem;
  logic [VW:0]        trial_diff;
  logic               trial_ge;
  logic [VW-1:0]      rem_d;
  logic               out_free;
  logic [TOTAL_W-1:0] total_base;
  logic [TOTAL_W-1:0] total_d;

  assign cand_bits = candidate_i[VW-1:0];

  // One restoring remainder step: bring in the next candidate bit, subtract
  // the divisor when it fits.
  assign trial_rem  = {rem_q, sh_q[VW-1]};
  assign trial_diff = trial_rem - {1'b0, div_q};
  assign trial_ge   = (trial_rem >= {1'b0, div_q});
  assign rem_d      = trial_ge ? trial_diff[VW-1:0] : trial_rem[VW-1:0];

  // The output register can load when empty or when its item leaves now.
  assign out_free = !out_valid_q || out_ready_i;

  // Running total after this item, with restart and saturation.
  always_comb begin
    total_base = restart_q ? '0 : total_q;
    total_d    = total_base;
    if (prime_q && (total_base != TOTAL_MAX)) begin
      total_d = total_base + TOTAL_W'(1);
    end
  end

  // Sequencer, divisor loop and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      value_q     <= '0;
      restart_q   <= 1'b0;
      div_q       <= '0;
      sq_q        <= '0;
      sh_q        <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      prime_q     <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      total_q     <= '0;
    end else begin
      // A taken result empties the register unless a new one loads now.
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            value_q   <= cand_bits;
            restart_q <= restart_i;
            div_q     <= VW'(FIRST_DIVISOR);
            sq_q      <= SW'(FIRST_DIVISOR * FIRST_DIVISOR);
            prime_q   <= 1'b0;
            if (cand_bits < VW'(FIRST_DIVISOR)) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          // Past the square root: no divisor found, so the value is prime.
          if (sq_q > {2'b00, value_q}) begin
            prime_q <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            sh_q    <= value_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          sh_q  <= {sh_q[VW-2:0], 1'b0};
          rem_q <= rem_d;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(VW - 1)) begin
            if (rem_d == '0) begin
              state_q <= ST_FINISH;
            end else begin
              // (d + 1)^2 = d^2 + 2d + 1
              sq_q    <= sq_q + {1'b0, div_q, 1'b1};
              div_q   <= div_q + VW'(1);
              state_q <= ST_CHECK;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            flag_q      <= prime_q;
            total_q     <= total_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign is_prime_flag_o = flag_q;
  assign prime_total_o   = total_q;

endmodule

@@ sv/tdpc_checker.sv @@
// ----------------------------------------------------------------------------
// Trial division prime counter checker
// Port-level assertions on the handshakes and the running total.
// ----------------------------------------------------------------------------
module tdpc_checker
  import tdpc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               is_prime_flag_o,
  input logic [TOTAL_W-1:0] prime_total_o
);

  // Total carried by the last delivered item.
  logic [TOTAL_W-1:0] last_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_total_q <= prime_total_o;
    end
  end

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_prime_flag_o)
      && $stable(prime_total_o))
    else $error("Result changed while stalled");

  // One item at a time: an accepted item blocks the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input ready right after an accepted item");

  // A prime is always counted, so the total cannot be zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_prime_flag_o |-> prime_total_o != '0)
    else $error("Prime delivered with a zero total");

  // A non-prime leaves the total as it was, or clears it on restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_prime_flag_o |->
      prime_total_o == last_total_q || prime_total_o == '0)
    else $error("Non-prime item changed the total");

  // A prime advances the total by one, saturates, or restarts at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_prime_flag_o |->
      prime_total_o == last_total_q + TOTAL_W'(1)
      || prime_total_o == TOTAL_W'(1)
      || (prime_total_o == TOTAL_MAX && last_total_q == TOTAL_MAX))
    else $error("Prime item gave a wrong total");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (.*);
